@@ rtl/core/psc_pkg.sv @@
package psc_pkg;

	localparam int LIMIT_W         = 16;
	localparam int COUNT_W         = 13;
	localparam int DEF_MAX_LIMIT   = 65535;
	localparam int DEF_MAX_BASE    = 64;
	localparam int STEP_W          = 4;
	localparam int NUM_STEPS       = 2 ** STEP_W;

	typedef logic [LIMIT_W-1:0] limit_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [STEP_W-1:0]  step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_FILL,
		OP_SQRT,
		OP_RD_I,
		OP_SQ_I,
		OP_CLR_I,
		OP_LIST,
		OP_K0,
		OP_RD_K,
		OP_SQ_P,
		OP_CLR_P,
		OP_K_INC,
		OP_CNT0,
		OP_CNT,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_A_LT_N,
		C_SQP_LE_N,
		C_I_GT_SQ,
		C_BIT_ZERO,
		C_J_LE_SQ,
		C_K_EQ_NB,
		C_J_LE_N,
		C_A_LE_N,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt;
	} ctl_word_t;

	typedef struct packed {
		logic req_fire;
		logic a_lt_n;
		logic sqp_le_n;
		logic i_gt_sq;
		logic bit_zero;
		logic j_le_sq;
		logic k_eq_nb;
		logic j_le_n;
		logic a_le_n;
		logic out_busy;
	} psc_flags_t;

	localparam step_t S_IDLE     = step_t'(0);
	localparam step_t S_FILL     = step_t'(1);
	localparam step_t S_SQRT     = step_t'(2);
	localparam step_t S_SS_CHK   = step_t'(3);
	localparam step_t S_SS_TEST  = step_t'(4);
	localparam step_t S_SS_MARK  = step_t'(5);
	localparam step_t S_SS_LIST  = step_t'(6);
	localparam step_t S_MK_INIT  = step_t'(7);
	localparam step_t S_MK_CHK   = step_t'(8);
	localparam step_t S_MK_LOAD  = step_t'(9);
	localparam step_t S_MK_MARK  = step_t'(10);
	localparam step_t S_MK_NEXT  = step_t'(11);
	localparam step_t S_CNT_INIT = step_t'(12);
	localparam step_t S_CNT      = step_t'(13);
	localparam step_t S_CNT_END  = step_t'(14);
	localparam step_t S_DONE     = step_t'(15);

	// jump to tgt when cond holds, else fall through; the last step wraps to idle
	localparam ctl_word_t UCODE [NUM_STEPS] = '{
		'{OP_LOAD,  C_NO_REQ,   S_IDLE},
		'{OP_FILL,  C_A_LT_N,   S_FILL},
		'{OP_SQRT,  C_SQP_LE_N, S_SQRT},
		'{OP_RD_I,  C_I_GT_SQ,  S_MK_INIT},
		'{OP_SQ_I,  C_BIT_ZERO, S_SS_CHK},
		'{OP_CLR_I, C_J_LE_SQ,  S_SS_MARK},
		'{OP_LIST,  C_ALWAYS,   S_SS_CHK},
		'{OP_K0,    C_NEVER,    S_MK_INIT},
		'{OP_RD_K,  C_K_EQ_NB,  S_CNT_INIT},
		'{OP_SQ_P,  C_NEVER,    S_MK_LOAD},
		'{OP_CLR_P, C_J_LE_N,   S_MK_MARK},
		'{OP_K_INC, C_ALWAYS,   S_MK_CHK},
		'{OP_CNT0,  C_NEVER,    S_SS_TEST},
		'{OP_CNT,   C_A_LE_N,   S_CNT},
		'{OP_NOP,   C_NEVER,    S_CNT_END},
		'{OP_EMIT,  C_OUT_BUSY, S_DONE}
	};

endpackage

@@ rtl/core/psc_if.sv @@
interface psc_req_if;
	import psc_pkg::*;

	logic   valid;
	logic   ready;
	limit_t limit;

	modport source (output valid, output limit, input ready);
	modport sink (input valid, input limit, output ready);
endinterface

interface psc_rsp_if;
	import psc_pkg::*;

	logic   valid;
	logic   ready;
	count_t prime_count;

	modport source (output valid, output prime_count, input ready);
	modport sink (input valid, input prime_count, output ready);
endinterface

@@ rtl/core/prime_sieve_counter.sv @@
// channel  dir  payload               request accepted
// req      in   limit [15:0]          req.valid && req.ready
// rsp      out  prime_count [12:0]    rsp.valid && rsp.ready
//
// One request at a time, for n = min(limit, MAX_LIMIT). All work goes through the
// single sieve bit memory, one access per cycle: fill n+1 entries, then mark the
// composites, then count the entries from 2 to n.
// Reset clears the step counter and the output valid; the memories need no clearing.
// A finished count waits in the output register while the next request is taken.
module prime_sieve_counter #(
	parameter int MAX_LIMIT       = psc_pkg::DEF_MAX_LIMIT,
	parameter int MAX_BASE_PRIMES = psc_pkg::DEF_MAX_BASE
) (
	input logic        clk,
	input logic        arst_n,
	psc_req_if.sink    req,
	psc_rsp_if.source  rsp
);
	import psc_pkg::*;

	localparam int LIM_W = $clog2(MAX_LIMIT + 1);
	localparam int SQ_W  = (LIM_W + 1) / 2;
	localparam int IW    = SQ_W + 1;
	localparam int WW    = LIM_W + 1;
	localparam int XW    = (LIM_W > LIMIT_W) ? LIM_W : LIMIT_W;
	localparam int LW    = $clog2(MAX_BASE_PRIMES);
	localparam int NB_W  = $clog2(MAX_BASE_PRIMES + 1);

	ctl_word_t  ctl;
	psc_flags_t flags;

	logic [LIM_W-1:0] n_q;
	logic [WW-1:0]    a_q;
	logic [WW-1:0]    j_q;
	logic [WW-1:0]    sqp_q;
	logic [SQ_W-1:0]  r_q;
	logic [IW-1:0]    i_q;
	logic [SQ_W-1:0]  p_q;
	logic [NB_W-1:0]  nb_q;
	logic [NB_W-1:0]  k_q;
	count_t           count_q;
	count_t           out_count_q;
	logic             out_valid_q;
	logic             rdv_q;

	logic             sieve_mem [MAX_LIMIT+1];
	logic             sv_rd_q;
	logic [SQ_W-1:0]  base_mem [MAX_BASE_PRIMES];
	logic [SQ_W-1:0]  base_rd_q;

	logic [XW-1:0]    limit_x;
	logic [LIM_W-1:0] n_sat;
	logic [2*IW-1:0]  i_sq;
	logic [2*SQ_W-1:0] p_sq;
	logic             req_fire;
	logic             nb_room;
	logic             sv_we;
	logic             sv_wd;
	logic [LIM_W-1:0] sv_wa;
	logic             sv_re;
	logic [LIM_W-1:0] sv_ra;
	logic             fill_bit;

	psc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	assign req.ready       = (ctl.op == OP_LOAD);
	assign req_fire        = req.valid && req.ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.prime_count = out_count_q;

	assign limit_x = XW'(req.limit);
	assign n_sat   = (limit_x > XW'(MAX_LIMIT)) ? LIM_W'(MAX_LIMIT) : LIM_W'(limit_x);
	assign i_sq    = i_q * i_q;
	assign p_sq    = base_rd_q * base_rd_q;
	assign nb_room = nb_q < NB_W'(MAX_BASE_PRIMES);

	assign flags.req_fire = req_fire;
	assign flags.a_lt_n   = a_q < WW'(n_q);
	assign flags.sqp_le_n = sqp_q <= WW'(n_q);
	assign flags.i_gt_sq  = i_q > IW'(r_q);
	assign flags.bit_zero = !sv_rd_q;
	assign flags.j_le_sq  = j_q <= WW'(r_q);
	assign flags.k_eq_nb  = k_q == nb_q;
	assign flags.j_le_n   = j_q <= WW'(n_q);
	assign flags.a_le_n   = a_q <= WW'(n_q);
	assign flags.out_busy = out_valid_q && !rsp.ready;

	// zero, one and even numbers above two start cleared
	assign fill_bit = (a_q == WW'(2)) || (a_q[0] && (a_q != WW'(1)));

	always_comb begin
		sv_we = 1'b0;
		sv_wd = 1'b0;
		sv_wa = j_q[LIM_W-1:0];
		sv_re = 1'b0;
		sv_ra = a_q[LIM_W-1:0];
		unique case (ctl.op)
			OP_FILL: begin
				sv_we = 1'b1;
				sv_wd = fill_bit;
				sv_wa = a_q[LIM_W-1:0];
			end
			OP_CLR_I: sv_we = flags.j_le_sq;
			OP_CLR_P: sv_we = flags.j_le_n;
			OP_RD_I: begin
				sv_re = 1'b1;
				sv_ra = LIM_W'(i_q);
			end
			OP_CNT:  sv_re = flags.a_le_n;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sv_we) begin
			sieve_mem[sv_wa] <= sv_wd;
		end
		if (sv_re) begin
			sv_rd_q <= sieve_mem[sv_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_LIST && nb_room) begin
			base_mem[nb_q[LW-1:0]] <= SQ_W'(i_q);
		end
		if (ctl.op == OP_RD_K) begin
			base_rd_q <= base_mem[k_q[LW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				if (req_fire) begin
					n_q   <= n_sat;
					a_q   <= '0;
					r_q   <= '0;
					sqp_q <= WW'(1);
					nb_q  <= '0;
				end
			end
			OP_FILL: a_q <= a_q + WW'(1);
			OP_SQRT: begin
				i_q <= IW'(3);
				if (flags.sqp_le_n) begin
					r_q   <= r_q + SQ_W'(1);
					sqp_q <= sqp_q + WW'({r_q, 1'b0}) + WW'(3);
				end
			end
			OP_SQ_I: begin
				j_q <= WW'(i_sq);
				if (!sv_rd_q) begin
					i_q <= i_q + IW'(2);
				end
			end
			OP_CLR_I: begin
				if (flags.j_le_sq) begin
					j_q <= j_q + WW'(i_q);
				end
			end
			OP_LIST: begin
				i_q <= i_q + IW'(2);
				if (nb_room) begin
					nb_q <= nb_q + NB_W'(1);
				end
			end
			OP_K0:   k_q <= '0;
			OP_SQ_P: begin
				p_q <= base_rd_q;
				j_q <= WW'(p_sq);
			end
			OP_CLR_P: begin
				if (flags.j_le_n) begin
					j_q <= j_q + WW'({p_q, 1'b0});
				end
			end
			OP_K_INC: k_q <= k_q + NB_W'(1);
			OP_CNT0:  a_q <= WW'(2);
			OP_CNT: begin
				if (flags.a_le_n) begin
					a_q <= a_q + WW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_CNT0) begin
			count_q <= '0;
		end else if (rdv_q && sv_rd_q) begin
			count_q <= count_q + count_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_EMIT && !flags.out_busy) begin
			out_count_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rdv_q       <= 1'b0;
		end else begin
			rdv_q <= (ctl.op == OP_CNT) && flags.a_le_n;
			if (ctl.op == OP_EMIT && !flags.out_busy) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/core/psc_seq.sv @@
module psc_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psc_pkg::psc_flags_t    flags,
	output psc_pkg::ctl_word_t     ctl
);
	import psc_pkg::*;

	step_t step_q;
	logic  take;

	assign ctl = UCODE[step_q];

	always_comb begin
		unique case (ctl.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_REQ:   take = !flags.req_fire;
			C_A_LT_N:   take = flags.a_lt_n;
			C_SQP_LE_N: take = flags.sqp_le_n;
			C_I_GT_SQ:  take = flags.i_gt_sq;
			C_BIT_ZERO: take = flags.bit_zero;
			C_J_LE_SQ:  take = flags.j_le_sq;
			C_K_EQ_NB:  take = flags.k_eq_nb;
			C_J_LE_N:   take = flags.j_le_n;
			C_A_LE_N:   take = flags.a_le_n;
			C_OUT_BUSY: take = flags.out_busy;
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (take) begin
			step_q <= ctl.tgt;
		end else begin
			step_q <= step_q + step_t'(1);
		end
	end
endmodule
